// ===== sv/crt_pkg.sv =====
// Package for the client rights table: field widths, op and status codes,
// parameter defaults and the result word type. No dependencies.
package crt_pkg;

	localparam int OP_W     = 3;
	localparam int TASK_W   = 16;
	localparam int RIGHTS_W = 32;
	localparam int ST_W     = 2;

	localparam int MAX_CLIENTS_DEF = 16;
	localparam int RIGHTS_BITS_DEF = 32;

	// request op codes
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET    = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [ST_W-1:0]     status;
		logic                found;
		logic [RIGHTS_W-1:0] rights_out;
		logic                check_ok;
	} res_t;

endpackage

// ===== sv/crt_if.sv =====
// Request and response channel interfaces for the client rights table.
// Depends on crt_pkg.
interface crt_req_if
	import crt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [TASK_W-1:0]   client_task;
	logic [RIGHTS_W-1:0] rights_in;

	modport source (output valid, op, client_task, rights_in, input ready);
	modport sink   (input valid, op, client_task, rights_in, output ready);
endinterface

interface crt_rsp_if
	import crt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ST_W-1:0]     status;
	logic                found;
	logic [RIGHTS_W-1:0] rights_out;
	logic                check_ok;

	modport source (output valid, status, found, rights_out, check_ok, input ready);
	modport sink   (input valid, status, found, rights_out, check_ok, output ready);
endinterface

// ===== sv/crt_out_reg.sv =====
// Output register of the client rights table: holds one result word until
// the sink takes it. Depends on crt_pkg and crt_rsp_if.
module crt_out_reg
	import crt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t din,
	output logic free,
	crt_rsp_if.source rsp
);

	logic vld_q;
	res_t data_q;

	// free when empty or the held word leaves this cycle
	assign free = !vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign rsp.valid      = vld_q;
	assign rsp.status     = data_q.status;
	assign rsp.found      = data_q.found;
	assign rsp.rights_out = data_q.rights_out;
	assign rsp.check_ok   = data_q.check_ok;

endmodule

// ===== sv/client_rights_table_top.sv =====
// Client rights table: task ids with rights masks, held in one slot memory.
// A request is scanned against the slots, one slot read a cycle through the
// single read port of the slot memory; a matching slot ends the scan early,
// and clear and unused ops skip the scan. A new request is taken only once
// the result of the last one is loaded into the output register.
// Reset clears all slot valid bits at once; memory contents are not reset.
module client_rights_table_top
	import crt_pkg::*;
#(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
	parameter int RIGHTS_BITS = RIGHTS_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	crt_req_if.sink   req,
	crt_rsp_if.source rsp
);

	localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW = $clog2(MAX_CLIENTS + 1);
	localparam int EW = TASK_W + RIGHTS_BITS;
	localparam logic [CW-1:0] CNT_END  = CW'(MAX_CLIENTS);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_CLIENTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_ACT  = 2'd2;

	logic [1:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [TASK_W-1:0]      task_q;
	logic [RIGHTS_BITS-1:0] rin_q;
	logic [CW-1:0]          cnt_q;
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [RIGHTS_BITS-1:0] old_q;
	logic                   free_q;
	logic [IW-1:0]          free_idx_q;
	logic [MAX_CLIENTS-1:0] valid_q;

	logic                   rd_vld_s1;
	logic [IW-1:0]          rd_idx_s1;
	logic [EW-1:0]          rd_data_s1;

	logic [EW-1:0]          mem [MAX_CLIENTS];

	logic                   acc;
	logic                   issue;
	logic [IW-1:0]          rd_addr;
	logic [TASK_W-1:0]      ent_task;
	logic [RIGHTS_BITS-1:0] ent_rights;
	logic                   slot_v;
	logic                   match;
	logic [RIGHTS_BITS-1:0] rin_m;

	logic                   act_we;
	logic [IW-1:0]          act_wa;
	logic [RIGHTS_BITS-1:0] act_wr;
	logic                   set_v;
	logic                   clr_v;
	logic                   clr_all;
	logic [RIGHTS_BITS-1:0] res_rights;
	logic [RIGHTS_W-1:0]    res_r32;
	res_t                   res;
	logic                   out_free;
	logic                   done;

	// request side
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;

	// fit the rights field to the stored width, both ways
	for (genvar g = 0; g < RIGHTS_BITS; g++) begin : g_rin
		if (g < RIGHTS_W) begin : g_bit
			assign rin_m[g] = req.rights_in[g];
		end else begin : g_zero
			assign rin_m[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < RIGHTS_W; g++) begin : g_rout
		if (g < RIGHTS_BITS) begin : g_bit
			assign res_r32[g] = res_rights[g];
		end else begin : g_zero
			assign res_r32[g] = 1'b0;
		end
	end

	// scan: one slot read issued a cycle, compared in the next cycle
	assign issue    = (state_q == S_SCAN) && (cnt_q != CNT_END);
	assign rd_addr  = cnt_q[IW-1:0];
	assign ent_task   = rd_data_s1[EW-1 -: TASK_W];
	assign ent_rights = rd_data_s1[RIGHTS_BITS-1:0];
	assign slot_v   = valid_q[rd_idx_s1];
	assign match    = rd_vld_s1 && slot_v && (ent_task == task_q);

	// slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (act_we && done) begin
			mem[act_wa] <= {task_q, act_wr};
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	// request fields and scan results
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= req.op;
			task_q <= req.client_task;
			rin_q  <= rin_m;
		end
		if (state_q == S_SCAN && match) begin
			hit_idx_q <= rd_idx_s1;
			old_q     <= ent_rights;
		end
		if (state_q == S_SCAN && rd_vld_s1 && !slot_v && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (req.op == OP_ADD || req.op == OP_REMOVE ||
						    req.op == OP_SET || req.op == OP_QUERY) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_ACT;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_vld_s1 && !slot_v && !free_q) begin
						free_q <= 1'b1;
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else if (rd_vld_s1 && rd_idx_s1 == IDX_LAST) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// apply the op and form the result word
	always_comb begin
		act_we     = 1'b0;
		act_wa     = hit_idx_q;
		act_wr     = rin_q;
		set_v      = 1'b0;
		clr_v      = 1'b0;
		clr_all    = 1'b0;
		res_rights = '0;
		res        = '0;
		unique case (op_q)
			OP_ADD: begin
				if (hit_q) begin
					act_we     = 1'b1;
					act_wr     = old_q | rin_q;
					res_rights = old_q | rin_q;
					res.found  = 1'b1;
				end else if (free_q) begin
					act_we     = 1'b1;
					act_wa     = free_idx_q;
					set_v      = 1'b1;
					res_rights = rin_q;
					res.found  = 1'b1;
				end else begin
					res.status = ST_NO_SPACE;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					clr_v = 1'b1;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				clr_all = 1'b1;
			end
			OP_SET: begin
				if (hit_q) begin
					act_we     = 1'b1;
					res_rights = rin_q;
					res.found  = 1'b1;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_QUERY: begin
				if (hit_q) begin
					res_rights   = old_q;
					res.found    = 1'b1;
					res.check_ok = ((old_q & rin_q) == rin_q);
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		res.rights_out = res_r32;
	end

	assign done = (state_q == S_ACT) && out_free;

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (done) begin
			if (clr_all) begin
				valid_q <= '0;
			end
			if (set_v) begin
				valid_q[act_wa] <= 1'b1;
			end
			if (clr_v) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	crt_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (done),
		.din    (res),
		.free   (out_free),
		.rsp    (rsp)
	);

	// checks
	a_check_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.check_ok |-> rsp.found)
		else $error("check_ok set on a word without found");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == ST_OK)
		else $error("found set with an error status");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("request taken while another is in work");

endmodule

// ===== dv/client_rights_table_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for client_rights_table_top: directed table, then random request
// sequences; each response is checked against an in-bench model of the table or a typed-in reply.
// Depends on crt_pkg, crt_if (crt_req_if, crt_rsp_if) and client_rights_table_top.
module client_rights_table_top_tb;
	import crt_pkg::*;

	localparam int ACL_SLOTS   = MAX_CLIENTS_DEF;
	localparam int POOL_N      = 24;
	localparam int PHASE_WORDS = 250;
	localparam int TAIL_CYCLES = ACL_SLOTS + 4;
	// worst honest quiet spell: longest sender gap + longest response stall + a full
	// scan, taken many times over
	localparam int STALL_LIMIT = 2000;
	localparam int DIR_ROWS    = 25;

	// op codes the block must ignore
	localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

	typedef enum int {IDLE_SOME, IDLE_NONE, IDLE_HEAVY} idle_mode_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [TASK_W-1:0]   tsk;
		logic [RIGHTS_W-1:0] rts;
		logic                typed;
		logic [ST_W-1:0]     st;
		logic                fnd;
		logic [RIGHTS_W-1:0] rout;
		logic                chk;
	} stim_row_t;

	logic clk;
	logic arst_n;

	crt_req_if req_ch ();
	crt_rsp_if rsp_ch ();

	client_rights_table_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model of the table
	logic                acl_valid  [ACL_SLOTS];
	logic [TASK_W-1:0]   acl_task   [ACL_SLOTS];
	logic [RIGHTS_W-1:0] acl_rights [ACL_SLOTS];

	res_t              pending_replies [$];
	logic [TASK_W-1:0] id_pool [POOL_N];
	idle_mode_t        idle_mode = IDLE_SOME;
	int                fail_count = 0;
	int                words_sent = 0;
	int                op_seen [8];
	int                no_space_seen = 0;
	int                not_found_seen = 0;
	int                check_pass_seen = 0;
	int                stall_left = 0;
	int                quiet_cycles = 0;

	// directed words; expected reply typed in where it is obvious, else modelled
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{OP_QUERY,    16'h0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0},
		'{OP_REMOVE,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0},
		'{OP_SET,      16'h1234, 32'hDEAD_BEEF, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0},
		'{OP_ADD,      16'h0000, 32'h0000_0000, 1'b1, ST_OK,        1'b1, 32'h0000_0000, 1'b0},
		'{OP_ADD,      16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,        1'b1, 32'hFFFF_FFFF, 1'b0},
		'{OP_QUERY,    16'hFFFF, 32'h0000_0000, 1'b1, ST_OK,        1'b1, 32'hFFFF_FFFF, 1'b1},
		'{OP_QUERY,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,        1'b1, 32'hFFFF_FFFF, 1'b1},
		'{OP_QUERY,    16'h0000, 32'h0000_0000, 1'b1, ST_OK,        1'b1, 32'h0000_0000, 1'b1},
		'{OP_ADD,      16'h0000, 32'h0000_00F0, 1'b1, ST_OK,        1'b1, 32'h0000_00F0, 1'b0},
		'{OP_ADD,      16'h0000, 32'h0000_000F, 1'b1, ST_OK,        1'b1, 32'h0000_00FF, 1'b0},
		'{OP_QUERY,    16'h0000, 32'h0000_01FF, 1'b1, ST_OK,        1'b1, 32'h0000_00FF, 1'b0},
		'{OP_SET,      16'h0000, 32'hA5A5_0000, 1'b1, ST_OK,        1'b1, 32'hA5A5_0000, 1'b0},
		'{OP_ADD,      16'h8000, 32'h5555_5555, 1'b0, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_QUERY,    16'h8000, 32'h4444_4444, 1'b0, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_QUERY,    16'h8000, 32'hAAAA_AAAA, 1'b0, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_RSVD_LO,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_RSVD_MID, 16'h0000, 32'h0000_0000, 1'b1, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_RSVD_HI,  16'h8000, 32'hFFFF_FFFF, 1'b1, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_REMOVE,   16'hFFFF, 32'h0000_0000, 1'b1, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_QUERY,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0},
		'{OP_SET,      16'h8000, 32'h0000_0001, 1'b0, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_ADD,      16'h0001, 32'h8000_0000, 1'b0, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_CLEAR,    16'h0000, 32'h0000_0000, 1'b1, ST_OK,        1'b0, 32'h0000_0000, 1'b0},
		'{OP_QUERY,    16'h0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0},
		'{OP_REMOVE,   16'h8000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0000_0000, 1'b0}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// slot holding a task, or -1
	function automatic int acl_find(input logic [TASK_W-1:0] tsk);
		int hit;
		hit = -1;
		for (int i = 0; i < ACL_SLOTS; i++) begin
			if (hit < 0 && acl_valid[i] && acl_task[i] == tsk)
				hit = i;
		end
		return hit;
	endfunction

	// apply one request to the model, return the reply it should produce
	function automatic res_t acl_apply(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] tsk,
			input logic [RIGHTS_W-1:0] rts);
		res_t r;
		int   hit;
		int   slot;
		r = '0;
		hit = acl_find(tsk);
		case (op)
			OP_ADD: begin
				if (hit >= 0) begin
					acl_rights[hit] = acl_rights[hit] | rts;
				end else begin
					slot = -1;
					for (int i = 0; i < ACL_SLOTS; i++) begin
						if (slot < 0 && !acl_valid[i])
							slot = i;
					end
					if (slot < 0) begin
						r.status = ST_NO_SPACE;
					end else begin
						acl_valid[slot]  = 1'b1;
						acl_task[slot]   = tsk;
						acl_rights[slot] = rts;
						hit = slot;
					end
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					acl_valid[hit] = 1'b0;
					hit = -1;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < ACL_SLOTS; i++)
					acl_valid[i] = 1'b0;
				hit = -1;
			end
			OP_SET: begin
				if (hit >= 0)
					acl_rights[hit] = rts;
				else
					r.status = ST_NOT_FOUND;
			end
			OP_QUERY: begin
				if (hit >= 0)
					r.check_ok = ((acl_rights[hit] & rts) == rts);
				else
					r.status = ST_NOT_FOUND;
			end
			default: begin
				hit = -1;
			end
		endcase
		if (hit >= 0) begin
			r.found      = 1'b1;
			r.rights_out = acl_rights[hit];
		end
		return r;
	endfunction

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap = 0;
		case (idle_mode)
			IDLE_NONE: gap = 0;
			IDLE_HEAVY: begin
				if (roll >= 80)
					gap = $urandom_range(10, 40);
				else if (roll >= 30)
					gap = $urandom_range(1, 5);
			end
			default: begin
				if (roll >= 92)
					gap = $urandom_range(8, 30);
				else if (roll >= 60)
					gap = $urandom_range(1, 3);
			end
		endcase
		return gap;
	endfunction

	function automatic logic [RIGHTS_W-1:0] random_rights();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		return RIGHTS_W'($urandom);
	endfunction

	// offer one word, wait for accept, record the expected reply, then maybe idle
	task automatic send_word(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] tsk,
			input logic [RIGHTS_W-1:0] rts, input logic typed = 1'b0, input res_t typed_res = '0);
		res_t modelled;
		int   gap;
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.client_task <= tsk;
		req_ch.rights_in   <= rts;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		modelled = acl_apply(op, tsk, rts);
		pending_replies.push_back(typed ? typed_res : modelled);
		op_seen[op]++;
		words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one request, mostly on the given task; op and rights picked at random
	task automatic send_random_op(input logic [TASK_W-1:0] pool_id);
		logic [OP_W-1:0]     op;
		logic [TASK_W-1:0]   tsk;
		logic [RIGHTS_W-1:0] rts;
		int                  roll;
		int                  slot;
		tsk  = pool_id;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			op = OP_ADD;
		else if (roll < 45)
			op = OP_REMOVE;
		else if (roll < 60)
			op = OP_SET;
		else if (roll < 95)
			op = OP_QUERY;
		else if (roll < 97)
			op = OP_CLEAR;
		else
			op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
		if ($urandom_range(0, 19) == 0)
			tsk = TASK_W'($urandom);
		rts = random_rights();
		// queries: often a subset or the exact mask, so check_ok sees both values
		if (op == OP_QUERY) begin
			slot = acl_find(tsk);
			roll = $urandom_range(0, 9);
			if (slot >= 0 && roll < 5)
				rts = acl_rights[slot] & RIGHTS_W'($urandom);
			else if (slot >= 0 && roll < 7)
				rts = acl_rights[slot];
		end
		send_word(op, tsk, rts);
	endtask

	// hold off the sender until every reply is back
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// response side back-pressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// reply checker
	always @(posedge clk) begin : reply_check
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_ch.status == ST_NO_SPACE)
				no_space_seen++;
			if (rsp_ch.status == ST_NOT_FOUND)
				not_found_seen++;
			if (rsp_ch.check_ok)
				check_pass_seen++;
			if (pending_replies.size() == 0) begin
				$error("reply word with nothing outstanding");
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
					fail_count++;
				end
				if (rsp_ch.rights_out !== want.rights_out) begin
					$error("rights_out: expected %h, got %h", want.rights_out,
						rsp_ch.rights_out);
					fail_count++;
				end
				if (rsp_ch.check_ok !== want.check_ok) begin
					$error("check_ok: expected %0d, got %0d", want.check_ok, rsp_ch.check_ok);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t row;
		res_t      typed_res;
		int        phase_start;
		int        roll;
		int        len;
		int        base;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_ADD;
		req_ch.client_task <= '0;
		req_ch.rights_in   <= '0;
		for (int i = 0; i < ACL_SLOTS; i++) begin
			acl_valid[i]  = 1'b0;
			acl_task[i]   = '0;
			acl_rights[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			op_seen[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			typed_res.status     = row.st;
			typed_res.found      = row.fnd;
			typed_res.rights_out = row.rout;
			typed_res.check_ok   = row.chk;
			send_word(row.op, row.tsk, row.rts, row.typed, typed_res);
		end
		drain_replies();

		// random phases: some idling, none, heavy idling
		for (int phase = 0; phase < 3; phase++) begin
			idle_mode = (phase == 0) ? IDLE_SOME : (phase == 1) ? IDLE_NONE : IDLE_HEAVY;
			for (int i = 0; i < POOL_N; i++)
				id_pool[i] = TASK_W'($urandom);
			id_pool[0]        = '0;
			id_pool[POOL_N-1] = '1;
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) begin
					// fill the table past its size so it runs out of slots
					if ($urandom_range(0, 1) == 1)
						send_word(OP_CLEAR, TASK_W'($urandom), RIGHTS_W'($urandom));
					base = $urandom_range(0, POOL_N - 1);
					len  = $urandom_range(ACL_SLOTS, ACL_SLOTS + 4);
					for (int k = 0; k < len; k++)
						send_word(OP_ADD, id_pool[(base + k) % POOL_N], random_rights());
				end else if (roll < 95) begin
					len = $urandom_range(4, 12);
					for (int k = 0; k < len; k++)
						send_random_op(id_pool[$urandom_range(0, POOL_N - 1)]);
				end else begin
					// raw noise over the whole field ranges
					len = $urandom_range(1, 4);
					for (int k = 0; k < len; k++)
						send_word(OP_W'($urandom), TASK_W'($urandom), RIGHTS_W'($urandom));
				end
			end
			drain_replies();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d words: %0d add, %0d remove, %0d clear, %0d set, %0d query, %0d unused",
			words_sent, op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_CLEAR], op_seen[OP_SET],
			op_seen[OP_QUERY], op_seen[OP_RSVD_LO] + op_seen[OP_RSVD_MID] + op_seen[OP_RSVD_HI]);
		$display("Replies: %0d table full, %0d task unknown, %0d rights checks held, %0d errors",
			no_space_seen, not_found_seen, check_pass_seen, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== client_rights_table_top.f =====
sv/crt_pkg.sv
sv/crt_if.sv
sv/crt_out_reg.sv
sv/client_rights_table_top.sv
dv/client_rights_table_top_tb.sv
